FILE: rtl/core/mlp_pkg.sv
// mlp_pkg: shared types, opcodes, sizes and fixed-point helpers for the MLP block.
// Depends on nothing; used by the MAC unit, the top level and the bench.
`timescale 1ns / 1ps
package mlp_pkg;
    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] CFG_INPUT_COUNT = 3'd0;
    localparam logic [2:0] CFG_HIDDEN_CNT  = 3'd1;
    localparam logic [2:0] CFG_WIDTH_0     = 3'd2;
    localparam logic [2:0] CFG_WIDTH_3     = 3'd5;
    localparam logic [2:0] CFG_GAIN        = 3'd6;
    localparam logic [2:0] CFG_OFFSET      = 3'd7;

    localparam int WIDTH_REGS        = 4;
    localparam int MAX_NEURONS       = 32;
    localparam int MAX_HIDDEN_LAYERS = 4;

    // Control from the sequencer to the MAC unit.
    typedef struct packed {
        logic load_bias;
        logic mac_en;
    } mac_ctrl_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction
endpackage

FILE: rtl/core/mlp_sigmoid_inference.sv
// mlp_sigmoid_inference: top level, memories, sequencer, sigmoid and output scaling.
// Depends on mlp_pkg and mlp_mac.
`timescale 1ns / 1ps
// How the block is used:
// Input transactions (opcode, layer_index, row_index, col_index, data_value,
// last_element) write weights, biases or input vector elements. An input element
// with last_element set is stored and then starts a forward pass. During the
// pass the input channel is not ready; one result transaction (prediction)
// follows and is held in an output register until the receiver takes it.
// Write transactions are accepted back to back while idle with no result
// waiting. For each neuron a forward pass fetches the bias, reads the weight
// memory once per column, drains the registered multiply and accumulate and
// applies the sigmoid; the output scaling of the last neuron's activation then
// yields the result. Weights, biases, inputs and activations live in
// synchronous memories with registered reads; they are not cleared at reset,
// and the block does not enforce that every entry is written before it is
// read: the user must do so. Reset restores the configuration registers and
// idles the sequencer. If the receiver stalls, the result waits in its register
// and no new input transaction is taken until it has gone. Configuration
// writes are accepted at any time but must only be issued while idle.
module mlp_sigmoid_inference #(
    parameter int FRAC_BITS         = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         layer_index,
    input  logic [4:0]         row_index,
    input  logic [4:0]         col_index,
    input  logic signed [31:0] data_value,
    input  logic               last_element,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] prediction,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int MAX_NEURONS       = mlp_pkg::MAX_NEURONS;
    localparam int MAX_HIDDEN_LAYERS = mlp_pkg::MAX_HIDDEN_LAYERS;
    localparam int LAYERS = MAX_HIDDEN_LAYERS + 1;
    localparam int NB = $clog2(MAX_NEURONS);
    localparam int LB = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int CB = NB + 1;
    localparam int HL = (MAX_HIDDEN_LAYERS < mlp_pkg::WIDTH_REGS) ?
                        MAX_HIDDEN_LAYERS : mlp_pkg::WIDTH_REGS;
    localparam int WDEPTH = LAYERS * MAX_NEURONS * MAX_NEURONS;
    localparam int BDEPTH = LAYERS * MAX_NEURONS;
    localparam int WAB = $clog2(WDEPTH);
    localparam int BAB = $clog2(BDEPTH);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [2:0] {S_IDLE, S_BIAS, S_MAC, S_DRAIN, S_ACT, S_SCALE, S_OUT}
        state_t;

    // Memories.
    logic signed [31:0] wmem [WDEPTH];
    logic signed [31:0] bmem [BDEPTH];
    logic signed [31:0] xmem [MAX_NEURONS];
    logic signed [31:0] amem [2*MAX_NEURONS];
    logic signed [31:0] w_rd, b_rd, x_rd, a_rd;

    // Configuration.
    logic [5:0]         input_count_reg;
    logic [2:0]         hidden_cnt_reg;
    logic [5:0]         width_reg [mlp_pkg::WIDTH_REGS];
    logic signed [31:0] gain_reg, offset_reg;

    state_t             state_reg;
    logic [LB-1:0]      layer_reg;
    logic [CB-1:0]      row_reg, col_reg, cols_reg, rows_reg;
    logic [2:0]         hc_reg;
    logic               issue_d_reg;
    logic [1:0]         drain_reg;
    logic signed [31:0] pred_reg;
    logic               out_valid_reg;
    logic signed [63:0] scale_reg;
    logic               src_in_reg;
    mlp_pkg::mac_ctrl_t ctrl;
    logic signed [31:0] acc;

    // Sigmoid working values.
    logic signed [32:0] m;
    logic signed [31:0] y, sig_y;

    logic in_fire;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    function automatic logic [CB-1:0] clampc(input logic [5:0] n);
        clampc = (32'(n) > MAX_NEURONS) ? CB'(MAX_NEURONS) : CB'(n);
    endfunction

    // Addresses.
    logic [WAB-1:0] w_wa, w_ra;
    logic [BAB-1:0] b_wa, b_ra;
    logic           w_ok, b_ok;
    assign w_ok = (32'(layer_index) < LAYERS) && (32'(row_index) < MAX_NEURONS) &&
                  (32'(col_index) < MAX_NEURONS);
    assign b_ok = (32'(layer_index) < LAYERS) && (32'(row_index) < MAX_NEURONS);
    assign w_wa = WAB'((32'(layer_index) * MAX_NEURONS + 32'(row_index)) * MAX_NEURONS
                  + 32'(col_index));
    assign b_wa = BAB'(32'(layer_index) * MAX_NEURONS + 32'(row_index));
    assign w_ra = WAB'((32'(layer_reg) * MAX_NEURONS + 32'(row_reg[NB-1:0])) *
                  MAX_NEURONS + 32'(col_reg[NB-1:0]));
    assign b_ra = BAB'(32'(layer_reg) * MAX_NEURONS + 32'(row_reg[NB-1:0]));

    // Source bank: layer l reads bank (l-1)&1 and writes bank l&1.
    logic [NB:0] a_ra, a_wa;
    assign a_ra = {~layer_reg[0], col_reg[NB-1:0]};
    assign a_wa = {layer_reg[0], row_reg[NB-1:0]};

    always_ff @(posedge clk)
    begin
        if (in_fire && opcode == mlp_pkg::OP_WEIGHT && w_ok)
            wmem[w_wa] <= data_value;
        if (in_fire && opcode == mlp_pkg::OP_BIAS && b_ok)
            bmem[b_wa] <= data_value;
        if (in_fire && opcode == mlp_pkg::OP_INPUT && 32'(col_index) < MAX_NEURONS)
            xmem[col_index[NB-1:0]] <= data_value;
        w_rd <= wmem[w_ra];
        b_rd <= bmem[b_ra];
        x_rd <= xmem[col_reg[NB-1:0]];
        a_rd <= amem[a_ra];
        if (state_reg == S_ACT)
            amem[a_wa] <= sig_y;
    end

    // Sigmoid of the saturated accumulator.
    always_comb
    begin
        m = (acc < 0) ? -33'(acc) : 33'(acc);
        if (m > 33'sd2147483647)
            m = 33'sd2147483647;
        if (m >= 33'(5) * 33'(ONE))
            y = ONE;
        else if (m >= (33'sd19 <<< (FRAC_BITS - 3)))
            y = 32'(m >>> 5) + (32'sd27 <<< (FRAC_BITS - 5));
        else if (m >= 33'(ONE))
            y = 32'(m >>> 3) + (32'sd5 <<< (FRAC_BITS - 3));
        else
            y = 32'(m >>> 2) + (ONE >>> 1);
        sig_y = (acc < 0) ? ONE - y : y;
    end

    // The weight read issued in S_MAC lands in the cycle after, while issue_d_reg
    // is high, so the product register is valid in the cycle after issue_d_reg.
    assign ctrl.load_bias = (state_reg == S_BIAS) && drain_reg == 2'd1;
    assign ctrl.mac_en    = issue_d_reg;

    mlp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .bias   (b_rd),
        .weight (w_rd),
        .act    (src_in_reg ? x_rd : a_rd),
        .acc    (acc)
    );

    logic signed [63:0] sh;
    logic signed [33:0] sum;
    assign sh  = scale_reg >>> FRAC_BITS;
    assign sum = ((sh > 64'sd2147483647) ? 34'sd2147483648 :
                  (sh < -64'sd2147483648) ? -34'sd2147483649 : 34'(signed'(sh[31:0])))
                 + 34'(offset_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg <= 6'd32;
            hidden_cnt_reg  <= 3'd1;
            for (int i = 0; i < mlp_pkg::WIDTH_REGS; i++)
                width_reg[i] <= 6'd32;
            gain_reg      <= 32'sd32855;
            offset_reg    <= 32'sd71999;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            issue_d_reg   <= 1'b0;
            drain_reg     <= '0;
            layer_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            cols_reg      <= '0;
            rows_reg      <= '0;
            hc_reg        <= '0;
            src_in_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mlp_pkg::CFG_INPUT_COUNT: input_count_reg <= cfg_data[5:0];
                    mlp_pkg::CFG_HIDDEN_CNT:  hidden_cnt_reg  <= cfg_data[2:0];
                    mlp_pkg::CFG_GAIN:        gain_reg        <= cfg_data;
                    mlp_pkg::CFG_OFFSET:      offset_reg      <= cfg_data;
                    default:
                        width_reg[2'(cfg_index - mlp_pkg::CFG_WIDTH_0)] <= cfg_data[5:0];
                endcase
            end
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            issue_d_reg <= (state_reg == S_MAC);
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && opcode == mlp_pkg::OP_INPUT && last_element)
                    begin
                        hc_reg     <= (32'(hidden_cnt_reg) > HL) ? 3'(HL) : hidden_cnt_reg;
                        layer_reg  <= '0;
                        row_reg    <= '0;
                        col_reg    <= '0;
                        cols_reg   <= clampc(input_count_reg);
                        rows_reg   <= (hidden_cnt_reg == 3'd0 || HL == 0) ? CB'(1) :
                                      clampc(width_reg[0]);
                        src_in_reg <= 1'b1;
                        drain_reg  <= '0;
                        state_reg  <= S_BIAS;
                    end
                end
                S_BIAS:
                begin
                    if (drain_reg == 2'd1)
                    begin
                        drain_reg <= '0;
                        state_reg <= (cols_reg == '0) ? S_DRAIN : S_MAC;
                    end
                    else
                        drain_reg <= drain_reg + 2'd1;
                end
                S_MAC:
                begin
                    col_reg     <= col_reg + CB'(1);
                    if (col_reg + CB'(1) == cols_reg)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd3)
                        state_reg <= S_ACT;
                end
                S_ACT:
                begin
                    drain_reg <= '0;
                    col_reg   <= '0;
                    if (3'(layer_reg) == hc_reg)
                    begin
                        pred_reg  <= sig_y;
                        state_reg <= S_SCALE;
                    end
                    else if (row_reg + CB'(1) == rows_reg)
                    begin
                        layer_reg  <= layer_reg + LB'(1);
                        row_reg    <= '0;
                        cols_reg   <= rows_reg;
                        src_in_reg <= 1'b0;
                        rows_reg   <= (3'(layer_reg) + 3'd1 == hc_reg) ? CB'(1) :
                                      clampc(width_reg[2'(layer_reg + LB'(1))]);
                        state_reg  <= S_BIAS;
                    end
                    else
                    begin
                        row_reg   <= row_reg + CB'(1);
                        state_reg <= S_BIAS;
                    end
                end
                S_SCALE:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd1)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    pred_reg      <= mlp_pkg::sat32(sum);
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= gain_reg * pred_reg;
    end

    assign out_valid  = out_valid_reg;
    assign prediction = pred_reg;
endmodule

FILE: rtl/core/mlp_mac.sv
// mlp_mac: registered multiply then saturating accumulate for one neuron.
// Depends on mlp_pkg.
`timescale 1ns / 1ps
module mlp_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mlp_pkg::mac_ctrl_t ctrl,
    input  logic signed [31:0] bias,
    input  logic signed [31:0] weight,
    input  logic signed [31:0] act,
    output logic signed [31:0] acc
);
    logic signed [63:0] prod_reg;
    logic               prod_vld_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic signed [63:0] shifted;
    logic signed [63:0] wide_sum;

    // Arithmetic shift of a signed value rounds towards minus infinity.
    assign shifted  = prod_reg >>> FRAC_BITS;
    assign wide_sum = 64'(acc_reg) + shifted;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load_bias)
            acc_next = bias;
        else if (prod_vld_reg)
        begin
            if (wide_sum > 64'sd2147483647)
                acc_next = 32'sh7fffffff;
            else if (wide_sum < -64'sd2147483648)
                acc_next = 32'sh80000000;
            else
                acc_next = wide_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mac_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * act;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;
endmodule

FILE: rtl/core/mlp_checker.sv
// mlp_checker: port-level assertions on the MLP block, bound to the top level.
// Depends on mlp_sigmoid_inference.
`timescale 1ns / 1ps
module mlp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] prediction
);
    // A held result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prediction))
        else $error("prediction changed while stalled");
    // No input is taken while a result waits.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");
    // A result appears only after a period of not ready.
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without compute");
endmodule

bind mlp_sigmoid_inference mlp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .prediction(prediction)
);

FILE: bench/tb.sv
// tb: self-checking bench for mlp_sigmoid_inference with its own forward-pass predictor.
// Depends on mlp_pkg and the block's RTL; stimulus comes from a queue filled per phase.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         layer;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] data;
        logic               last;
    } net_item_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         opcode;
    logic [2:0]         layer_index;
    logic [4:0]         row_index;
    logic [4:0]         col_index;
    logic signed [31:0] data_value;
    logic               last_element;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] prediction;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    mlp_sigmoid_inference i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .layer_index(layer_index), .row_index(row_index),
        .col_index(col_index), .data_value(data_value), .last_element(last_element),
        .out_valid(out_valid), .out_ready(out_ready), .prediction(prediction),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Items waiting to be offered, and predictions waiting for their result transaction.
    net_item_t          pending_items[$];
    logic signed [31:0] expected_predictions[$];

    int  error_count;
    int  result_count;
    int  compute_count;
    int  item_count;
    int  phase_count;
    bit  quiet;

    // Mirror of the block's stores and registers, updated on accepted transactions.
    logic signed [31:0] m_weight[5][32][32];
    logic signed [31:0] m_bias[5][32];
    logic signed [31:0] m_input[32];
    logic [5:0]         m_in_count;
    logic [2:0]         m_hidden;
    logic [5:0]         m_width[4];
    logic signed [31:0] m_gain;
    logic signed [31:0] m_offset;

    // Which entries the stimulus has already written, so no compute reads an unwritten one.
    bit gen_weight[5][32][32];
    bit gen_bias[5][32];
    bit gen_input[32];
    int g_in_count;
    int g_hidden;
    int g_width[4];

    // Clock; the one reset at the start of the run comes from the stimulus block.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_count(input int n);
        return (n > 32) ? 32 : n;
    endfunction

    function automatic logic signed [31:0] saturate(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Piecewise linear logistic curve, symmetric about 0.5.
    function automatic logic signed [31:0] logistic(input logic signed [31:0] z);
        longint m;
        longint y;
        m = (z < 0) ? -longint'(z) : longint'(z);
        if (m > 64'sd2147483647)
            m = 64'sd2147483647;
        if (m >= 5 * 65536)
            y = 65536;
        else if (m >= (64'sd19 << 13))
            y = (m >> 5) + (64'sd27 << 11);
        else if (m >= 65536)
            y = (m >> 3) + (64'sd5 << 13);
        else
            y = (m >> 2) + 32768;
        if (z < 0)
            y = 65536 - y;
        return y[31:0];
    endfunction

    // Forward pass over the mirrored stores; only neuron zero of the last layer is needed.
    function automatic logic signed [31:0] forward_pass();
        logic signed [31:0] src[32];
        logic signed [31:0] dst[32];
        logic signed [31:0] final_act;
        longint acc;
        int layers;
        int cols;
        int rows;
        layers = (m_hidden > 4) ? 4 : m_hidden;
        cols = clamp_count(m_in_count);
        src = m_input;
        final_act = 0;
        for (int l = 0; l <= layers; l++)
        begin
            rows = (l < layers) ? clamp_count(m_width[l]) : 1;
            for (int r = 0; r < rows; r++)
            begin
                acc = m_bias[l][r];
                for (int c = 0; c < cols; c++)
                    acc = saturate(acc + ((longint'(m_weight[l][r][c]) *
                                           longint'(src[c])) >>> 16));
                dst[r] = logistic(acc[31:0]);
            end
            if (l == layers)
                final_act = dst[0];
            src = dst;
            cols = rows;
        end
        return saturate(((longint'(m_gain) * longint'(final_act)) >>> 16) + longint'(m_offset));
    endfunction

    // Data values: mostly within a few units so that every region of the curve is reached.
    function automatic logic signed [31:0] rand_data();
        case ($urandom_range(0, 7))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 524287)) - 32'sd262144;
        endcase
    endfunction

    task automatic push_item(input logic [1:0] op, input int layer, input int row, input int col,
                             input logic signed [31:0] data, input bit last);
        net_item_t it;
        it.op = op;
        it.layer = layer[2:0];
        it.row = row[4:0];
        it.col = col[4:0];
        it.data = data;
        it.last = last;
        if (op == mlp_pkg::OP_WEIGHT && layer < 5)
            gen_weight[layer][row][col] = 1'b1;
        if (op == mlp_pkg::OP_BIAS && layer < 5)
            gen_bias[layer][row] = 1'b1;
        if (op == mlp_pkg::OP_INPUT)
            gen_input[col] = 1'b1;
        pending_items.push_back(it);
        item_count++;
    endtask

    // One forward pass: fills in whatever the current sizes need, adds some noise, then starts it.
    task automatic push_compute();
        int layers;
        int cols;
        int rows;
        layers = (g_hidden > 4) ? 4 : g_hidden;
        cols = clamp_count(g_in_count);
        for (int l = 0; l <= layers; l++)
        begin
            rows = (l < layers) ? clamp_count(g_width[l]) : 1;
            for (int r = 0; r < rows; r++)
            begin
                if (!gen_bias[l][r] || $urandom_range(0, 9) == 0)
                    push_item(mlp_pkg::OP_BIAS, l, r, 0, rand_data(), 1'b0);
                for (int c = 0; c < cols; c++)
                    if (!gen_weight[l][r][c] || $urandom_range(0, 9) == 0)
                        push_item(mlp_pkg::OP_WEIGHT, l, r, c, rand_data(),
                                  $urandom_range(0, 1));
            end
            cols = rows;
        end
        for (int c = 0; c < clamp_count(g_in_count); c++)
            if (!gen_input[c] || $urandom_range(0, 2) == 0)
                push_item(mlp_pkg::OP_INPUT, 0, 0, c, rand_data(), 1'b0);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0: push_item(mlp_pkg::OP_NONE, $urandom_range(0, 7), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom, $urandom_range(0, 1));
                1: push_item($urandom_range(0, 1) ? mlp_pkg::OP_BIAS : mlp_pkg::OP_WEIGHT,
                             $urandom_range(5, 7), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom, $urandom_range(0, 1));
                default: push_item($urandom_range(0, 1) ? mlp_pkg::OP_BIAS
                                                        : mlp_pkg::OP_WEIGHT,
                                   $urandom_range(0, 4),
                                   $urandom_range(0, 31), $urandom_range(0, 31),
                                   rand_data(), $urandom_range(0, 1));
            endcase
        end
        push_item(mlp_pkg::OP_INPUT, $urandom_range(0, 7), $urandom_range(0, 31),
                  $urandom_range(0, 31), rand_data(), 1'b1);
        compute_count++;
    endtask

    // Waits until the block has nothing in flight, then lets a few cycles pass.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_predictions.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Writes all eight registers back to back, holding valid across them.
    task automatic write_config(input int ic, input int hc, input int w0, input int w1,
                                input int w2, input int w3, input logic [31:0] gain,
                                input logic [31:0] offset);
        logic [31:0] vals[8];
        vals = '{ic, hc, w0, w1, w2, w3, gain, offset};
        g_in_count = ic;
        g_hidden = hc;
        g_width = '{w0, w1, w2, w3};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        phase_count++;
    endtask

    // Random sizes, kept to at most 160 multiply-accumulates and bias loads per pass.
    task automatic random_config();
        int ic;
        int hc;
        int w[4];
        int cost;
        int cols;
        int rows;
        do
        begin
            ic = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32 : 63)
                                             : $urandom_range(0, 6);
            hc = $urandom_range(0, 7);
            for (int k = 0; k < 4; k++)
                w[k] = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 32 : 63)
                                                   : $urandom_range(0, 5);
            cost = 0;
            cols = clamp_count(ic);
            for (int l = 0; l <= ((hc > 4) ? 4 : hc); l++)
            begin
                rows = (l < ((hc > 4) ? 4 : hc)) ? clamp_count(w[l]) : 1;
                cost += rows * (cols + 1);
                cols = rows;
            end
        end
        while (cost > 160);
        write_config(ic, hc, w[0], w[1], w[2], w[3],
                     ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 196608),
                     ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 131072));
    endtask

    // Stimulus: a directed phase, fixed extremes, then random phases, quiet once over 420 items are queued.
    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        error_count = 0;
        result_count = 0;
        compute_count = 0;
        item_count = 0;
        phase_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single neuron, unit gain: saturation, ignored items and each region of the curve.
        write_config(1, 0, 1, 1, 1, 1, 32'd65536, 32'd0);
        push_item(mlp_pkg::OP_WEIGHT, 0, 0, 0, 32'sh7fffffff, 1'b1);
        push_item(mlp_pkg::OP_BIAS, 0, 0, 0, 32'sh80000000, 1'b1);
        push_item(mlp_pkg::OP_INPUT, 0, 0, 0, 32'sh7fffffff, 1'b1);
        push_item(mlp_pkg::OP_NONE, 7, 31, 31, 32'sh7fffffff, 1'b1);
        push_item(mlp_pkg::OP_WEIGHT, 5, 31, 31, 32'sh55555555, 1'b0);
        push_item(mlp_pkg::OP_BIAS, 7, 31, 0, 32'shaaaaaaaa, 1'b0);
        push_item(mlp_pkg::OP_INPUT, 7, 31, 31, 32'sh80000000, 1'b0);
        push_item(mlp_pkg::OP_BIAS, 0, 0, 0, 32'sh7fffffff, 1'b0);
        push_item(mlp_pkg::OP_INPUT, 0, 0, 0, 32'sh80000000, 1'b1);
        push_item(mlp_pkg::OP_WEIGHT, 0, 0, 0, 32'sd65536, 1'b0);
        push_item(mlp_pkg::OP_BIAS, 0, 0, 0, 32'sd0, 1'b0);
        for (int k = 0; k < 10; k++)
        begin
            logic signed [31:0] pts[10];
            pts = '{0, 32768, 98304, 196608, 393216, -32768, -98304, -196608, -393216, 155648};
            push_item(mlp_pkg::OP_INPUT, 0, 0, 0, pts[k], 1'b1);
            compute_count++;
        end
        compute_count += 2;
        wait_idle();

        // Full input vector, extreme gain and offset.
        write_config(63, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff);
        repeat (2) push_compute();
        wait_idle();

        // Empty first sum, too many hidden layers, widths of zero and above the maximum.
        write_config(0, 7, 63, 1, 0, 2, 32'h80000000, 32'h80000000);
        repeat (2) push_compute();
        wait_idle();

        while (item_count < 500)
        begin
            if (item_count > 420)
                quiet = 1'b1;
            random_config();
            repeat ($urandom_range(3, 8)) push_compute();
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("Covered %0d input items and %0d forward passes over %0d configurations.",
                 item_count, compute_count, phase_count);
        $display("%0d predictions checked, %0d mismatches.", result_count, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Sender: offers queued items, with random bursts of idle cycles between them.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        net_item_t it;
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= '0;
            layer_index <= '0;
            row_index <= '0;
            col_index <= '0;
            data_value <= '0;
            last_element <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            gap = send_gap;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= gap - 1;
            end
            else if (pending_items.size() == 0)
                in_valid <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 14);
            end
            else
            begin
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                opcode <= it.op;
                layer_index <= it.layer;
                row_index <= it.row;
                col_index <= it.col;
                data_value <= it.data;
                last_element <= it.last;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off once a few results have come.
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && result_count >= 3)
        begin
            out_ready <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: mirrors accepted writes, predicts each forward pass and checks each result.
    always @(posedge clk)
    begin
        logic signed [31:0] want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mlp_pkg::CFG_INPUT_COUNT: m_in_count = cfg_data[5:0];
                    mlp_pkg::CFG_HIDDEN_CNT:  m_hidden = cfg_data[2:0];
                    mlp_pkg::CFG_GAIN:        m_gain = cfg_data;
                    mlp_pkg::CFG_OFFSET:      m_offset = cfg_data;
                    default:
                        m_width[2'(cfg_index - mlp_pkg::CFG_WIDTH_0)] = cfg_data[5:0];
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (opcode == mlp_pkg::OP_WEIGHT && layer_index < 5)
                    m_weight[layer_index][row_index][col_index] = data_value;
                else if (opcode == mlp_pkg::OP_BIAS && layer_index < 5)
                    m_bias[layer_index][row_index] = data_value;
                else if (opcode == mlp_pkg::OP_INPUT)
                begin
                    m_input[col_index] = data_value;
                    if (last_element)
                        expected_predictions.push_back(forward_pass());
                end
            end
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_predictions.size() == 0)
                begin
                    $display("%0t: unexpected prediction, expected none, actual %0d",
                             $time, prediction);
                    error_count++;
                end
                else
                begin
                    want = expected_predictions.pop_front();
                    if (prediction !== want)
                    begin
                        $display("%0t: prediction mismatch, expected %0d, actual %0d",
                                 $time, want, prediction);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: any channel moving resets the count of quiet cycles.
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end
endmodule
